// ===== rtl/core/bfs_pkg.sv =====
// ----------------------------------------------------------------------------
// bfs_pkg: shared types and constants
// Opcodes, result status codes, datapath command and status bundles for the
// shortest-hop search engine.
// ----------------------------------------------------------------------------
package bfs_pkg;

  localparam int MAX_NODES_DEF  = 256;
  localparam int MAX_DEGREE_DEF = 8;

  localparam int NODE_W = 8;
  localparam int HOPS_W = 8;

  localparam logic [NODE_W-1:0] NV_RESET = 8'd255;

  // input opcodes
  localparam logic [1:0] OP_CLEAR    = 2'd0;
  localparam logic [1:0] OP_ADD_EDGE = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;

  // result status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_RANGE = 2'd2;

  // datapath micro-operations, one per cycle
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLR_DEG,
    DP_RD_DEG_A,
    DP_RD_DEG_B,
    DP_CAP_DB,
    DP_WR_EDGE1,
    DP_WR_EDGE2,
    DP_CLR_DIST,
    DP_SEED,
    DP_RD_QUEUE,
    DP_RD_CUR,
    DP_CAP_DEG,
    DP_RD_NBR,
    DP_RD_NDIST,
    DP_VISIT,
    DP_RD_DST
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       emit;
    logic       emit_hit;
    logic [1:0] emit_status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       out_of_range;
    logic       add_full;
    logic       sweep_last;
    logic       queue_empty;
    logic       deg_done;
    logic       dst_hit;
  } sts_t;

endpackage

// ===== rtl/core/bfs_ram.sv =====
// ----------------------------------------------------------------------------
// bfs_ram: generic single-port-write RAM
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module bfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/bfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfs_ctrl: sequencing state machine
// Issues one datapath operation per cycle for clear, add-edge and query items.
// ----------------------------------------------------------------------------
module bfs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  bfs_pkg::sts_t sts,
  output bfs_pkg::cmd_t cmd
);

  import bfs_pkg::*;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_CLR_G,
    S_ADD_A,
    S_ADD_B,
    S_ADD_CHK,
    S_ADD_W2,
    S_QCLR,
    S_SEED,
    S_POP,
    S_CUR,
    S_DEG,
    S_NBR,
    S_NDIST,
    S_VISIT,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt       = state_r;
    cmd.op          = DP_NOP;
    cmd.emit        = 1'b0;
    cmd.emit_hit    = 1'b0;
    cmd.emit_status = STS_OK;
    case (state_r)
      S_INIT: begin
        cmd.op = DP_CLR_DEG;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.op    = DP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.opcode)
          OP_CLEAR: begin
            state_nxt = S_CLR_G;
          end
          OP_ADD_EDGE: begin
            if (sts.out_of_range) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = STS_RANGE;
              state_nxt       = S_IDLE;
            end else begin
              cmd.op    = DP_RD_DEG_A;
              state_nxt = S_ADD_A;
            end
          end
          OP_QUERY: begin
            if (sts.out_of_range) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = STS_RANGE;
              state_nxt       = S_IDLE;
            end else begin
              state_nxt = S_QCLR;
            end
          end
          default: begin
            cmd.emit  = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_CLR_G: begin
        cmd.op = DP_CLR_DEG;
        if (sts.sweep_last) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_ADD_A: begin
        cmd.op    = DP_RD_DEG_B;
        state_nxt = S_ADD_B;
      end
      S_ADD_B: begin
        cmd.op    = DP_CAP_DB;
        state_nxt = S_ADD_CHK;
      end
      S_ADD_CHK: begin
        if (sts.add_full) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = STS_FULL;
          state_nxt       = S_IDLE;
        end else begin
          cmd.op    = DP_WR_EDGE1;
          state_nxt = S_ADD_W2;
        end
      end
      S_ADD_W2: begin
        cmd.op    = DP_WR_EDGE2;
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_QCLR: begin
        cmd.op = DP_CLR_DIST;
        if (sts.sweep_last) begin
          state_nxt = S_SEED;
        end
      end
      S_SEED: begin
        cmd.op    = DP_SEED;
        state_nxt = S_POP;
      end
      S_POP: begin
        if (sts.queue_empty) begin
          cmd.op    = DP_RD_DST;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = DP_RD_QUEUE;
          state_nxt = S_CUR;
        end
      end
      S_CUR: begin
        cmd.op    = DP_RD_CUR;
        state_nxt = S_DEG;
      end
      S_DEG: begin
        cmd.op    = DP_CAP_DEG;
        state_nxt = S_NBR;
      end
      S_NBR: begin
        if (sts.deg_done) begin
          state_nxt = S_POP;
        end else begin
          cmd.op    = DP_RD_NBR;
          state_nxt = S_NDIST;
        end
      end
      S_NDIST: begin
        cmd.op    = DP_RD_NDIST;
        state_nxt = S_VISIT;
      end
      S_VISIT: begin
        cmd.op    = DP_VISIT;
        state_nxt = S_NBR;
      end
      S_FIN: begin
        cmd.emit     = 1'b1;
        cmd.emit_hit = sts.dst_hit;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/bfs_dpath.sv =====
// ----------------------------------------------------------------------------
// bfs_dpath: graph storage and search datapath
// Degree, adjacency, distance and queue memories with their address muxing,
// item registers, search pointers and the result register.
// ----------------------------------------------------------------------------
module bfs_dpath #(
  parameter int MAX_NODES  = bfs_pkg::MAX_NODES_DEF,
  parameter int MAX_DEGREE = bfs_pkg::MAX_DEGREE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [bfs_pkg::NODE_W-1:0]   cfg_wr_data,
  input  logic [1:0]                   in_opcode,
  input  logic [bfs_pkg::NODE_W-1:0]   in_node_a,
  input  logic [bfs_pkg::NODE_W-1:0]   in_node_b,
  input  bfs_pkg::cmd_t                cmd,
  output bfs_pkg::sts_t                sts,
  output logic                         out_valid,
  output logic [bfs_pkg::HOPS_W-1:0]   out_hops,
  output logic                         out_reachable,
  output logic [1:0]                   out_status
);

  import bfs_pkg::*;

  localparam int NW        = $clog2(MAX_NODES);
  localparam int KW        = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int DW        = $clog2(MAX_DEGREE + 1);
  localparam int NBR_DEPTH = MAX_NODES * (2 ** KW);
  localparam int DIST_W    = HOPS_W + 1;

  logic [NODE_W-1:0] nv_r;
  logic [1:0]        op_r;
  logic [NODE_W-1:0] a_r, b_r;
  logic [DW-1:0]     da_r, db_r, deg_r, k_r;
  logic [NW-1:0]     cur_r, nbr_r, cnt_r;
  logic [HOPS_W-1:0] d_r;
  logic [NW:0]       head_r, tail_r;
  logic              out_valid_r, out_reach_r;
  logic [HOPS_W-1:0] out_hops_r;
  logic [1:0]        out_status_r;

  logic [NW-1:0]     a_idx, b_idx;
  logic              is_self, tail_full, sweep_last, do_visit;
  logic [DW-1:0]     da_inc;
  logic [HOPS_W-1:0] d_cur;

  // memory ports
  logic              deg_we;
  logic [NW-1:0]     deg_waddr, deg_raddr;
  logic [DW-1:0]     deg_wdata, deg_rdata;
  logic              nbr_we;
  logic [NW+KW-1:0]  nbr_waddr, nbr_raddr;
  logic [NW-1:0]     nbr_wdata, nbr_rdata;
  logic              dist_we;
  logic [NW-1:0]     dist_waddr, dist_raddr;
  logic [DIST_W-1:0] dist_wdata, dist_rdata;
  logic              q_we;
  logic [NW-1:0]     q_waddr, q_wdata, q_raddr, q_rdata;

  assign a_idx      = NW'(a_r);
  assign b_idx      = NW'(b_r);
  assign is_self    = (a_r == b_r);
  assign tail_full  = (tail_r == (NW+1)'(MAX_NODES));
  assign sweep_last = (cnt_r == NW'(MAX_NODES - 1));
  assign da_inc     = da_r + DW'(1);
  assign do_visit   = !dist_rdata[DIST_W-1] && !tail_full;
  assign d_cur      = dist_rdata[HOPS_W-1:0];

  always_comb begin
    sts.opcode       = op_r;
    sts.out_of_range = (a_r > nv_r) || (b_r > nv_r) ||
                       (32'(a_r) > 32'(MAX_NODES - 1)) ||
                       (32'(b_r) > 32'(MAX_NODES - 1));
    if (is_self) begin
      sts.add_full = (32'(da_r) + 32'd2 > 32'(MAX_DEGREE));
    end else begin
      sts.add_full = (32'(da_r) >= 32'(MAX_DEGREE)) || (32'(db_r) >= 32'(MAX_DEGREE));
    end
    sts.sweep_last  = sweep_last;
    sts.queue_empty = (head_r == tail_r);
    sts.deg_done    = (k_r == deg_r);
    sts.dst_hit     = dist_rdata[DIST_W-1];
  end

  always_comb begin
    deg_we     = 1'b0;
    deg_waddr  = a_idx;
    deg_wdata  = '0;
    nbr_we     = 1'b0;
    nbr_waddr  = {a_idx, da_r[KW-1:0]};
    nbr_wdata  = a_idx;
    dist_we    = 1'b0;
    dist_waddr = nbr_r;
    dist_wdata = '0;
    q_we       = 1'b0;
    q_waddr    = tail_r[NW-1:0];
    q_wdata    = nbr_r;
    case (cmd.op)
      DP_CLR_DEG: begin
        deg_we    = 1'b1;
        deg_waddr = cnt_r;
      end
      DP_WR_EDGE1: begin
        deg_we    = 1'b1;
        deg_wdata = is_self ? (da_r + DW'(2)) : da_inc;
        nbr_we    = 1'b1;
        nbr_wdata = is_self ? a_idx : b_idx;
      end
      DP_WR_EDGE2: begin
        deg_we    = !is_self;
        deg_waddr = b_idx;
        deg_wdata = db_r + DW'(1);
        nbr_we    = 1'b1;
        nbr_waddr = is_self ? {a_idx, da_inc[KW-1:0]} : {b_idx, db_r[KW-1:0]};
        nbr_wdata = a_idx;
      end
      DP_CLR_DIST: begin
        dist_we    = 1'b1;
        dist_waddr = cnt_r;
      end
      DP_SEED: begin
        dist_we    = 1'b1;
        dist_waddr = a_idx;
        dist_wdata = {1'b1, HOPS_W'(0)};
        q_we       = 1'b1;
        q_waddr    = '0;
        q_wdata    = a_idx;
      end
      DP_VISIT: begin
        dist_we    = do_visit;
        dist_wdata = {1'b1, d_r};
        q_we       = do_visit;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (cmd.op)
      DP_RD_DEG_B: deg_raddr = b_idx;
      DP_RD_CUR:   deg_raddr = q_rdata;
      default:     deg_raddr = a_idx;
    endcase
    case (cmd.op)
      DP_RD_CUR:   dist_raddr = q_rdata;
      DP_RD_NDIST: dist_raddr = nbr_rdata;
      default:     dist_raddr = b_idx;
    endcase
  end

  assign q_raddr   = head_r[NW-1:0];
  assign nbr_raddr = {cur_r, k_r[KW-1:0]};

  bfs_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_deg_ram (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr),
    .wdata (deg_wdata),
    .raddr (deg_raddr),
    .rdata (deg_rdata)
  );

  bfs_ram #(.WIDTH(NW), .DEPTH(NBR_DEPTH)) u_nbr_ram (
    .clk   (clk),
    .we    (nbr_we),
    .waddr (nbr_waddr),
    .wdata (nbr_wdata),
    .raddr (nbr_raddr),
    .rdata (nbr_rdata)
  );

  bfs_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_dist_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (dist_raddr),
    .rdata (dist_rdata)
  );

  bfs_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r        <= NV_RESET;
      cnt_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        nv_r <= cfg_wr_data;
      end
      if (cmd.op == DP_CLR_DEG || cmd.op == DP_CLR_DIST) begin
        cnt_r <= sweep_last ? '0 : cnt_r + NW'(1);
      end
      if (cmd.op == DP_SEED) begin
        head_r <= '0;
        tail_r <= (NW+1)'(1);
      end
      if (cmd.op == DP_RD_QUEUE) begin
        head_r <= head_r + (NW+1)'(1);
      end
      if (cmd.op == DP_VISIT && do_visit) begin
        tail_r <= tail_r + (NW+1)'(1);
      end
      out_valid_r <= cmd.emit;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        op_r <= in_opcode;
        a_r  <= in_node_a;
        b_r  <= in_node_b;
      end
      DP_RD_DEG_B: da_r  <= deg_rdata;
      DP_CAP_DB:   db_r  <= deg_rdata;
      DP_RD_CUR:   cur_r <= q_rdata;
      DP_CAP_DEG: begin
        deg_r <= deg_rdata;
        d_r   <= (d_cur == '1) ? d_cur : d_cur + HOPS_W'(1);
        k_r   <= '0;
      end
      DP_RD_NBR:   k_r   <= k_r + DW'(1);
      DP_RD_NDIST: nbr_r <= nbr_rdata;
      default: begin
      end
    endcase
    if (cmd.emit) begin
      out_hops_r   <= cmd.emit_hit ? dist_rdata[HOPS_W-1:0] : '0;
      out_reach_r  <= cmd.emit_hit;
      out_status_r <= cmd.emit_status;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hops      = out_hops_r;
  assign out_reachable = out_reach_r;
  assign out_status    = out_status_r;

endmodule

// ===== rtl/core/bfs_shortest_hops_engine_core.sv =====
// Clear, add edge and query each run as a sequence of datapath operations, with every
// memory read registered; out-of-range items are answered from the decode state.
// Throughput: one item at a time; busy falls with the result strobe, so start is taken again
// at the edge that ends the strobe cycle. Reset: synchronous, active low; afterwards a
// pass zeroes the degree memory with busy high. Receiver cannot stall.
// ----------------------------------------------------------------------------
// bfs_shortest_hops_engine_core: shortest-hop search engine top level
// Bounded adjacency-list graph store with a breadth-first search over it.
// ----------------------------------------------------------------------------
//
// Structure
//   bfs_ctrl  - state machine, one datapath operation per cycle
//   bfs_dpath - four RAMs (degree, adjacency, distance, visit queue) and the
//               registers for the item in flight, search pointers and result
//
// Item flow
//   An item transfers on start while busy is low. Every item yields exactly
//   one result transfer: out_valid is high for one cycle with out_hops,
//   out_reachable and out_status.
//   Clear sweeps the degree memory to zero; adjacency entries stay but are
//   never read past a node's degree.
//   Add edge reads both degrees, checks free slots, then writes the two
//   adjacency entries and degrees. A self loop takes two slots in its own
//   list.
//   Query sweeps the distance memory clear, seeds the queue with the source,
//   then pops nodes and scans their lists, marking and enqueueing each
//   unvisited neighbor with a saturating hop count. Finally the destination's
//   distance entry is read.
//
// Configuration
//   cfg_wr_en/cfg_wr_data write the highest valid node index (reset 255).
//   Write only while idle.
// ----------------------------------------------------------------------------
module bfs_shortest_hops_engine_core #(
  parameter int MAX_NODES  = bfs_pkg::MAX_NODES_DEF,
  parameter int MAX_DEGREE = bfs_pkg::MAX_DEGREE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_wr_en,
  input  logic [bfs_pkg::NODE_W-1:0] cfg_wr_data,
  // command channel
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_opcode,
  input  logic [bfs_pkg::NODE_W-1:0] in_node_a,
  input  logic [bfs_pkg::NODE_W-1:0] in_node_b,
  // result channel
  output logic                       out_valid,
  output logic [bfs_pkg::HOPS_W-1:0] out_hops,
  output logic                       out_reachable,
  output logic [1:0]                 out_status
);

  import bfs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bfs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  bfs_dpath #(
    .MAX_NODES  (MAX_NODES),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_opcode     (in_opcode),
    .in_node_a     (in_node_a),
    .in_node_b     (in_node_b),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_hops      (out_hops),
    .out_reachable (out_reachable),
    .out_status    (out_status)
  );

endmodule

// ===== verif/tb_bfs_shortest_hops_engine_core.sv =====
// ----------------------------------------------------------------------------
// tb_bfs_shortest_hops_engine_core: self-checking bench for the hop engine
// Drives clear / add-edge / query commands, first from a directed table and
// then in random phases under several vertex limits and sender idle rates.
// Each result transfer is compared field by field with a behavioral model of
// the adjacency store and the breadth-first search, or with a pinned table value.
// ----------------------------------------------------------------------------
module tb_bfs_shortest_hops_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bfs_pkg::*;

  localparam int NODES   = MAX_NODES_DEF;
  localparam int DEG_MAX = MAX_DEGREE_DEF;

  // opcode 3 has no name in the package; the engine must treat it as a no-op
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // the limit must cover a worst-case query, during which there is no transfer
  localparam int STALL_LIMIT  = 60000;
  localparam int REPORT_LIMIT = 10;
  localparam int POOL_SIZE    = 16;

  // random phases: vertex limit, sender idle percent, command count.
  // 15 -> 6 lowers the limit without a clear, so searches may cross
  // nodes that are now out of range.
  localparam int N_PHASES = 6;
  localparam int PHASE_NV    [N_PHASES] = '{255, 15,  6,  1, 200, 255};
  localparam int PHASE_IDLE  [N_PHASES] = '{ 22, 22, 81, 81,   0,   0};
  localparam int PHASE_ITEMS [N_PHASES] = '{ 45, 45, 45, 40,  45,  45};

  typedef struct packed {
    logic [HOPS_W-1:0] hops;
    logic              reachable;
    logic [1:0]        status;
  } hop_result_t;

  // a pinned row carries its result typed in; otherwise the model decides
  typedef struct packed {
    logic        pinned;
    hop_result_t val;
  } result_hint_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [1:0]        op;
    logic [NODE_W-1:0] a;     // vertex limit on a config row
    logic [NODE_W-1:0] b;
    logic              pinned;
    hop_result_t       want;
  } stim_row_t;

  localparam hop_result_t R_NONE  = '{8'd0, 1'b0, STS_OK};
  localparam hop_result_t R_SAME  = '{8'd0, 1'b1, STS_OK};
  localparam hop_result_t R_ONE   = '{8'd1, 1'b1, STS_OK};
  localparam hop_result_t R_FULL  = '{8'd0, 1'b0, STS_FULL};
  localparam hop_result_t R_RANGE = '{8'd0, 1'b0, STS_RANGE};

  localparam int N_ROWS = 26;

  // directed part, starts from the reset graph with vertex limit 255
  stim_row_t directed_rows [N_ROWS] = '{
    '{ROW_ITEM, OP_QUERY,    8'd0,   8'd0,   1'b1, R_SAME},  // source is destination
    '{ROW_ITEM, OP_QUERY,    8'd0,   8'd255, 1'b1, R_NONE},  // empty graph
    '{ROW_ITEM, OP_UNUSED,   8'd255, 8'd255, 1'b1, R_NONE},  // unused opcode
    '{ROW_ITEM, OP_ADD_EDGE, 8'd0,   8'd255, 1'b1, R_NONE},  // extreme endpoints
    '{ROW_ITEM, OP_QUERY,    8'd255, 8'd0,   1'b1, R_ONE},
    '{ROW_ITEM, OP_ADD_EDGE, 8'd255, 8'd255, 1'b1, R_NONE},  // self loop
    '{ROW_ITEM, OP_ADD_EDGE, 8'd170, 8'd85,  1'b0, R_NONE},
    '{ROW_ITEM, OP_ADD_EDGE, 8'd85,  8'd0,   1'b0, R_NONE},
    '{ROW_ITEM, OP_QUERY,    8'd170, 8'd255, 1'b0, R_NONE},  // three hops
    '{ROW_ITEM, OP_ADD_EDGE, 8'd0,   8'd255, 1'b0, R_NONE},  // duplicate edge
    '{ROW_ITEM, OP_ADD_EDGE, 8'd1,   8'd1,   1'b0, R_NONE},
    '{ROW_ITEM, OP_ADD_EDGE, 8'd1,   8'd1,   1'b0, R_NONE},
    '{ROW_ITEM, OP_ADD_EDGE, 8'd1,   8'd1,   1'b0, R_NONE},
    '{ROW_ITEM, OP_ADD_EDGE, 8'd1,   8'd2,   1'b0, R_NONE},  // node 1 one short of full
    '{ROW_ITEM, OP_ADD_EDGE, 8'd1,   8'd1,   1'b1, R_FULL},  // self loop, one free slot
    '{ROW_ITEM, OP_ADD_EDGE, 8'd1,   8'd3,   1'b0, R_NONE},  // fills node 1
    '{ROW_ITEM, OP_ADD_EDGE, 8'd1,   8'd4,   1'b1, R_FULL},  // list full, dropped
    '{ROW_ITEM, OP_QUERY,    8'd2,   8'd3,   1'b0, R_NONE},
    '{ROW_ITEM, OP_CLEAR,    8'hA5,  8'h5A,  1'b1, R_NONE},
    '{ROW_ITEM, OP_QUERY,    8'd0,   8'd255, 1'b1, R_NONE},  // lists gone after clear
    '{ROW_CFG,  OP_CLEAR,    8'd1,   8'd0,   1'b0, R_NONE},  // smallest vertex limit
    '{ROW_ITEM, OP_ADD_EDGE, 8'd0,   8'd1,   1'b1, R_NONE},
    '{ROW_ITEM, OP_ADD_EDGE, 8'd2,   8'd1,   1'b1, R_RANGE}, // node out of range
    '{ROW_ITEM, OP_QUERY,    8'd1,   8'd0,   1'b1, R_ONE},
    '{ROW_ITEM, OP_QUERY,    8'd0,   8'd255, 1'b1, R_RANGE},
    '{ROW_ITEM, OP_ADD_EDGE, 8'd1,   8'd1,   1'b0, R_NONE}
  };

  // DUT signals
  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [NODE_W-1:0] cfg_wr_data;
  logic              start;
  logic              busy;
  logic [1:0]        in_opcode;
  logic [NODE_W-1:0] in_node_a;
  logic [NODE_W-1:0] in_node_b;
  logic              out_valid;
  logic [HOPS_W-1:0] out_hops;
  logic              out_reachable;
  logic [1:0]        out_status;

  bfs_shortest_hops_engine_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .start        (start),
    .busy         (busy),
    .in_opcode    (in_opcode),
    .in_node_a    (in_node_a),
    .in_node_b    (in_node_b),
    .out_valid    (out_valid),
    .out_hops     (out_hops),
    .out_reachable(out_reachable),
    .out_status   (out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Graph model: degree per node, adjacency slots, per-query distance marks.
  // Apart from their initialization, only the check process below touches these.
  // --------------------------------------------------------------------------
  logic [3:0]        deg_mem  [NODES];
  logic [NODE_W-1:0] nbr_mem  [NODES*DEG_MAX];
  logic [8:0]        dist_mem [NODES];    // bit 8 = visited, 7..0 = hops
  logic [NODE_W-1:0] vertex_limit;

  initial begin
    vertex_limit = NV_RESET;
    foreach (deg_mem[i]) deg_mem[i] = '0;
  end

  // BFS from src; distance saturates at 255
  function automatic hop_result_t bfs_hops(input logic [NODE_W-1:0] src,
                                           input logic [NODE_W-1:0] dst);
    int          order [NODES];
    int          head;
    int          tail;
    int          cur;
    int          nbr;
    int          d;
    int          deg;
    hop_result_t r;
    foreach (dist_mem[i]) dist_mem[i] = '0;
    dist_mem[src] = 9'h100;
    order[0] = src;
    head = 0;
    tail = 1;
    while (head < tail) begin
      cur = order[head];
      head++;
      deg = (deg_mem[cur] > DEG_MAX) ? DEG_MAX : deg_mem[cur];
      d = dist_mem[cur][7:0];
      if (d < 255) d++;
      for (int k = 0; k < deg; k++) begin
        nbr = nbr_mem[cur*DEG_MAX + k];
        if (!dist_mem[nbr][8] && tail < NODES) begin
          dist_mem[nbr] = {1'b1, 8'(d)};
          order[tail] = nbr;
          tail++;
        end
      end
    end
    r = R_NONE;
    if (dist_mem[dst][8]) begin
      r.hops      = dist_mem[dst][7:0];
      r.reachable = 1'b1;
    end
    return r;
  endfunction

  // one command against the model; updates the graph, returns its result
  function automatic hop_result_t apply_command(input logic [1:0]        op,
                                                input logic [NODE_W-1:0] a,
                                                input logic [NODE_W-1:0] b);
    int          da;
    int          db;
    hop_result_t r;
    r = R_NONE;
    case (op)
      OP_CLEAR: begin
        foreach (deg_mem[i]) deg_mem[i] = '0;
      end
      OP_ADD_EDGE, OP_QUERY: begin
        da = deg_mem[a];
        db = deg_mem[b];
        if (a > vertex_limit || b > vertex_limit) begin
          r.status = STS_RANGE;           // range check wins over full check
        end else if (op == OP_QUERY) begin
          r = bfs_hops(a, b);
        end else if (a == b) begin
          // self loop takes two slots of its own list
          if (da + 2 > DEG_MAX) begin
            r.status = STS_FULL;
          end else begin
            nbr_mem[a*DEG_MAX + da]     = a;
            nbr_mem[a*DEG_MAX + da + 1] = a;
            deg_mem[a] = 4'(da + 2);
          end
        end else if (da >= DEG_MAX || db >= DEG_MAX) begin
          r.status = STS_FULL;
        end else begin
          nbr_mem[a*DEG_MAX + da] = b;
          nbr_mem[b*DEG_MAX + db] = a;
          deg_mem[a] = 4'(da + 1);
          deg_mem[b] = 4'(db + 1);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking and watchdog. Everything is sampled at the rising edge,
  // before the DUT's registers update, so no ordering within the step matters.
  // --------------------------------------------------------------------------
  hop_result_t  expected_results [$];
  result_hint_t pinned_results   [$];

  int n_sent     = 0;   // raised by the sender
  int n_accepted = 0;
  int n_results  = 0;
  int n_errors   = 0;
  int n_reached  = 0;
  int n_full     = 0;
  int n_range    = 0;
  int stall_cycles = 0;

  always @(posedge clk) begin : result_check
    hop_result_t  got;
    hop_result_t  exp_r;
    hop_result_t  calc;
    result_hint_t hint;
    if (rst_n) begin
      // results first: a command taken this edge cannot have its result yet
      if (out_valid) begin
        got = '{out_hops, out_reachable, out_status};
        n_results++;
        if (expected_results.size() == 0) begin
          n_errors++;
          if (n_errors <= REPORT_LIMIT)
            $display("[%0t] result with nothing pending: hops=%0d reach=%0b status=%0d",
                     $time, got.hops, got.reachable, got.status);
        end else begin
          exp_r = expected_results.pop_front();
          if (got.hops !== exp_r.hops || got.reachable !== exp_r.reachable ||
              got.status !== exp_r.status) begin
            n_errors++;
            if (n_errors <= REPORT_LIMIT)
              $display({"[%0t] result #%0d: exp hops=%0d reach=%0b status=%0d,",
                        " got hops=%0d reach=%0b status=%0d"},
                       $time, n_results, exp_r.hops, exp_r.reachable, exp_r.status,
                       got.hops, got.reachable, got.status);
          end
        end
      end

      if (cfg_wr_en) vertex_limit = cfg_wr_data;

      if (start && !busy) begin
        n_accepted++;
        hint = pinned_results.pop_front();
        calc = apply_command(in_opcode, in_node_a, in_node_b);
        exp_r = hint.pinned ? hint.val : calc;
        expected_results.insert(expected_results.size(), exp_r);
        if (exp_r.reachable) n_reached++;
        if (exp_r.status == STS_FULL) n_full++;
        if (exp_r.status == STS_RANGE) n_range++;
      end
    end

    // watchdog: a run of edges with no transfer on either side
    if ((start && !busy) || out_valid) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               STALL_LIMIT, expected_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  int idle_pct;

  // random idle edges before the command, then hold start until busy is low
  task automatic send_command(input logic [1:0]        op,
                              input logic [NODE_W-1:0] a,
                              input logic [NODE_W-1:0] b,
                              input logic              pinned,
                              input hop_result_t       want);
    result_hint_t hint;
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    hint = '{pinned, want};
    pinned_results.insert(pinned_results.size(), hint);
    start     <= 1'b1;
    in_opcode <= op;
    in_node_a <= a;
    in_node_b <= b;
    n_sent++;
    do @(posedge clk); while (busy);
  endtask

  // every sent command answered and the engine idle
  task automatic wait_drained();
    start <= 1'b0;
    while (n_results < n_sent || busy) @(posedge clk);
  endtask

  task automatic set_vertex_limit(input logic [NODE_W-1:0] v);
    wait_drained();
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin : stimulus
    logic [NODE_W-1:0] pool [POOL_SIZE];
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic [1:0]        op;
    int                pick;

    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    start       <= 1'b0;
    in_opcode   <= OP_CLEAR;
    in_node_a   <= '0;
    in_node_b   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed table; start is only taken once the post-reset sweep is done
    idle_pct = PHASE_IDLE[0];
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        set_vertex_limit(directed_rows[i].a);
      else
        send_command(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                     directed_rows[i].pinned, directed_rows[i].want);
    end

    // random phases: mostly edges and queries inside a small node pool so
    // the searches walk real paths, plus some clears and unconstrained noise
    for (int p = 0; p < N_PHASES; p++) begin
      set_vertex_limit(8'(PHASE_NV[p]));
      idle_pct = PHASE_IDLE[p];
      foreach (pool[j]) pool[j] = 8'($urandom_range(PHASE_NV[p], 0));
      for (int i = 0; i < PHASE_ITEMS[p]; i++) begin
        pick = $urandom_range(99, 0);
        a = pool[$urandom_range(POOL_SIZE-1, 0)];
        b = pool[$urandom_range(POOL_SIZE-1, 0)];
        if (pick < 6) begin
          op = OP_CLEAR;
        end else if (pick < 50) begin
          op = OP_ADD_EDGE;
        end else if (pick < 88) begin
          op = OP_QUERY;
        end else begin
          op = 2'($urandom_range(3, 0));
          a  = 8'($urandom_range(255, 0));
          b  = 8'($urandom_range(255, 0));
        end
        send_command(op, a, b, 1'b0, R_NONE);
      end
    end

    wait_drained();
    repeat (16) @(posedge clk);    // room for a stray extra result
    if (expected_results.size() != 0) begin
      n_errors++;
      $display("%0d expected results never arrived", expected_results.size());
    end

    $display({"Run covered %0d commands: %0d queries reached their target,",
              " %0d edges dropped on full lists, %0d node range errors."},
             n_accepted, n_reached, n_full, n_range);
    $display("Vertex limits swept from 1 to 255 over %0d phases, sender idle at 22, 81 and 0 percent.",
             N_PHASES);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
